/* src/tfgm_pkg.sv */
// ----------------------------------------------------------------------------
// tfgm_pkg
// Types, codes and helper functions shared by the frame gap monitor modules.
// ----------------------------------------------------------------------------
package tfgm_pkg;

    localparam int NUM_SPANS_DEFAULT = 2;
    localparam int OUT_FIFO_DEPTH    = 8;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 288;
    localparam int TIME_W      = 52;

    typedef enum logic [2:0] {
        CLS_NOT_TDM    = 3'd0,
        CLS_FIRST      = 3'd1,
        CLS_SECOND     = 3'd2,
        CLS_OTHER      = 3'd3,
        CLS_SPAN_RANGE = 3'd4
    } frame_class_t;

    typedef enum logic [1:0] {
        GAP_NONE = 2'd0,
        GAP_IN   = 2'd1,
        GAP_OUT  = 2'd2
    } gap_status_t;

    // Request into the timing stage.
    typedef struct packed {
        frame_class_t        cls;
        logic                oerr;
        logic [TIME_W-1:0]   now;
    } tim_req_t;

    // Result of the timing stage, handed on to the statistics stage.
    typedef struct packed {
        frame_class_t  cls;
        gap_status_t   status;
        logic [31:0]   gap;
        logic          oerr;
        logic [31:0]   frames;
        logic [31:0]   oerr_count;
        logic          in_window;
        logic [19:0]   gap_short;
    } tim_res_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [63:0]   gap_square_sum;
        logic [47:0]   gap_sum;
        logic [31:0]   accepted_count;
        logic [31:0]   order_error_count;
        logic [19:0]   max_gap_us;
        logic [19:0]   min_gap_us;
        logic [31:0]   frame_count;
        logic          order_error;
        logic [31:0]   gap_us;
        gap_status_t   gap_status;
        frame_class_t  frame_class;
    } result_t;

    function automatic logic [31:0] inc_sat32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic is_stream(input frame_class_t c);
        return (c == CLS_FIRST) || (c == CLS_SECOND);
    endfunction

endpackage

/* src/tfgm_timing.sv */
// ----------------------------------------------------------------------------
// tfgm_timing
// Per-stream timing memory: last timestamp, frame count and order error count,
// read through a registered port, updated and written back with one-entry forwarding.
// ----------------------------------------------------------------------------
module tfgm_timing #(
    parameter int  NUM_SPANS = tfgm_pkg::NUM_SPANS_DEFAULT,
    localparam int SPAN_W    = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1,
    localparam int STREAM_W  = SPAN_W + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [19:0]          gap_low,
    input  logic [19:0]          gap_high,
    input  logic [STREAM_W-1:0]  rd_idx,
    input  logic                 cur_valid,
    input  logic [STREAM_W-1:0]  cur_idx,
    input  tfgm_pkg::tim_req_t   cur,
    output tfgm_pkg::tim_res_t   res
);

    localparam int NUM_STREAMS = 2 * NUM_SPANS;

    typedef struct packed {
        logic [tfgm_pkg::TIME_W-1:0] last_time;
        logic [31:0]                 frames;
        logic [31:0]                 oerr_count;
    } tim_entry_t;

    tim_entry_t                mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0]    seen_reg;
    tim_entry_t                rd_data_reg;
    logic                      rd_seen_reg;
    logic                      fwd_valid_reg;
    logic [STREAM_W-1:0]       fwd_idx_reg;
    tim_entry_t                fwd_data_reg;

    logic                          wr_en;
    logic                          fwd_hit;
    logic                          old_seen;
    tim_entry_t                    base;
    tim_entry_t                    new_entry;
    logic                          late;
    logic                          in_window;
    logic [tfgm_pkg::TIME_W-1:0]   delta;

    // Memory port: registered read, single write.
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[rd_idx];
        rd_seen_reg  <= seen_reg[rd_idx];
        fwd_idx_reg  <= cur_idx;
        fwd_data_reg <= new_entry;
        if (wr_en)
        begin
            mem[cur_idx] <= new_entry;
        end
    end

    // The seen bits double as valid bits for the memory entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
            if (wr_en)
            begin
                seen_reg[cur_idx] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_en    = cur_valid && tfgm_pkg::is_stream(cur.cls);
        fwd_hit  = fwd_valid_reg && (fwd_idx_reg == cur_idx);
        old_seen = fwd_hit || rd_seen_reg;
        if (fwd_hit)
        begin
            base = fwd_data_reg;
        end
        else if (rd_seen_reg)
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = '0;
        end

        late      = cur.now < base.last_time;
        delta     = cur.now - base.last_time;
        in_window = old_seen && !late
                    && (delta >= {32'd0, gap_low}) && (delta <= {32'd0, gap_high});

        new_entry.last_time  = cur.now;
        new_entry.frames     = tfgm_pkg::inc_sat32(base.frames);
        new_entry.oerr_count = cur.oerr ? tfgm_pkg::inc_sat32(base.oerr_count)
                                        : base.oerr_count;

        res     = '0;
        res.cls = cur.cls;
        if (tfgm_pkg::is_stream(cur.cls))
        begin
            res.oerr       = cur.oerr;
            res.frames     = new_entry.frames;
            res.oerr_count = new_entry.oerr_count;
            res.in_window  = in_window;
            res.gap_short  = delta[19:0];
            if (!old_seen)
            begin
                res.status = tfgm_pkg::GAP_NONE;
                res.gap    = '0;
            end
            else
            begin
                res.status = in_window ? tfgm_pkg::GAP_IN : tfgm_pkg::GAP_OUT;
                res.gap    = (late || (|delta[tfgm_pkg::TIME_W-1:32])) ? '1 : delta[31:0];
            end
        end
    end

endmodule

/* src/tfgm_stats.sv */
// ----------------------------------------------------------------------------
// tfgm_stats
// Per-stream gap statistics memory: min, max, in-window count, sum and sum of
// squares. Read through a registered port, updated on in-window gaps, with forwarding.
// ----------------------------------------------------------------------------
module tfgm_stats #(
    parameter int  NUM_SPANS = tfgm_pkg::NUM_SPANS_DEFAULT,
    localparam int SPAN_W    = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1,
    localparam int STREAM_W  = SPAN_W + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [STREAM_W-1:0]  rd_idx,
    input  logic                 cur_valid,
    input  logic [STREAM_W-1:0]  cur_idx,
    input  tfgm_pkg::tim_res_t   cur,
    output tfgm_pkg::result_t    res
);

    localparam int          NUM_STREAMS   = 2 * NUM_SPANS;
    localparam logic [19:0] MIN_GAP_RESET = 20'd999999;

    typedef struct packed {
        logic [19:0] min_gap;
        logic [19:0] max_gap;
        logic [31:0] accepted;
        logic [47:0] gap_sum;
        logic [63:0] square_sum;
    } stat_entry_t;

    stat_entry_t             mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0]  valid_reg;
    stat_entry_t             rd_data_reg;
    logic                    rd_valid_reg;
    logic                    fwd_valid_reg;
    logic [STREAM_W-1:0]     fwd_idx_reg;
    stat_entry_t             fwd_data_reg;

    logic          wr_en;
    logic          fwd_hit;
    stat_entry_t   base;
    stat_entry_t   new_entry;
    logic [19:0]   g;
    logic [39:0]   square;
    logic [48:0]   sum_ext;
    logic [64:0]   sq_ext;

    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[rd_idx];
        rd_valid_reg <= valid_reg[rd_idx];
        fwd_idx_reg  <= cur_idx;
        fwd_data_reg <= new_entry;
        if (wr_en)
        begin
            mem[cur_idx] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
            if (wr_en)
            begin
                valid_reg[cur_idx] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_en   = cur_valid && cur.in_window;
        fwd_hit = fwd_valid_reg && (fwd_idx_reg == cur_idx);
        if (fwd_hit)
        begin
            base = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            base = rd_data_reg;
        end
        else
        begin
            // An entry never written holds the reset statistics.
            base         = '0;
            base.min_gap = MIN_GAP_RESET;
        end

        g       = cur.gap_short;
        square  = {20'd0, g} * {20'd0, g};
        sum_ext = {1'b0, base.gap_sum} + {29'd0, g};
        sq_ext  = {1'b0, base.square_sum} + {25'd0, square};

        new_entry = base;
        if (cur.in_window)
        begin
            new_entry.min_gap    = (g < base.min_gap) ? g : base.min_gap;
            new_entry.max_gap    = (g > base.max_gap) ? g : base.max_gap;
            new_entry.accepted   = tfgm_pkg::inc_sat32(base.accepted);
            new_entry.gap_sum    = sum_ext[48] ? '1 : sum_ext[47:0];
            new_entry.square_sum = sq_ext[64] ? '1 : sq_ext[63:0];
        end

        res             = '0;
        res.frame_class = cur.cls;
        if (tfgm_pkg::is_stream(cur.cls))
        begin
            res.gap_status        = cur.status;
            res.gap_us            = cur.gap;
            res.order_error       = cur.oerr;
            res.frame_count       = cur.frames;
            res.order_error_count = cur.oerr_count;
            res.min_gap_us        = new_entry.min_gap;
            res.max_gap_us        = new_entry.max_gap;
            res.accepted_count    = new_entry.accepted;
            res.gap_sum           = new_entry.gap_sum;
            res.gap_square_sum    = new_entry.square_sum;
        end
    end

endmodule

/* src/tfgm_out_fifo.sv */
// ----------------------------------------------------------------------------
// tfgm_out_fifo
// Result queue between the pipeline and the output stream.
// ----------------------------------------------------------------------------
module tfgm_out_fifo #(
    parameter int  DEPTH = tfgm_pkg::OUT_FIFO_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = PTR_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tfgm_pkg::result_t  push_data,
    input  logic               pop,
    output tfgm_pkg::result_t  head,
    output logic               not_empty,
    output logic [CNT_W-1:0]   count
);

    tfgm_pkg::result_t  slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head      = slots[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* src/tdm_frame_gap_monitor.sv */
// ----------------------------------------------------------------------------
// tdm_frame_gap_monitor
// Classifies captured frames and keeps per-stream inter-frame gap statistics
// for TDM-over-Ethernet traffic, one result item for each input item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  s_*       in         s_tvalid / s_tready        s_tdata: one captured frame
//  m_*       out        m_tvalid / m_tready        m_tdata: class, gap, statistics
//  APB       in/out     psel, penable, pwrite      paddr, pwdata, prdata (64 bit)
//
// The block takes one item in every cycle while s_tready is high. An accepted
// item passes through four stages (classify and timestamp multiply, timestamp
// add, timing memory update, statistics memory update) and its result is
// pushed into the result queue that drives m_tvalid. The two per-stream
// memories are read from the stage before and written back with one-entry
// forwarding, so frames of the same stream may follow each other in
// consecutive cycles.
// Reset needs no clearing pass: each memory entry has a valid bit, and an
// entry not yet written reads as the reset statistics.
// Results queue in an eight-entry buffer; s_tready falls once the queued and
// in-flight items together fill it, so a stalled output never loses an item.
//
module tdm_frame_gap_monitor #(
    parameter int  NUM_SPANS = tfgm_pkg::NUM_SPANS_DEFAULT,
    localparam int SPAN_W    = (NUM_SPANS > 1) ? $clog2(NUM_SPANS) : 1,
    localparam int STREAM_W  = SPAN_W + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: source_mac 48, ether_type 16, span_number 16,
    // time_seconds 32, time_micros 20, zero padding 4.
    input  logic [tfgm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result item.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: frame_class 3, gap_status 2, gap_us 32,
    // order_error 1, frame_count 32, min_gap_us 20, max_gap_us 20,
    // order_error_count 32, accepted_count 32, gap_sum 48,
    // gap_square_sum 64, zero padding 2.
    output logic [tfgm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [5:0]                          paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready
);

    localparam logic [2:0]  REG_FIRST_MAC  = 3'd0;
    localparam logic [2:0]  REG_SECOND_MAC = 3'd1;
    localparam logic [2:0]  REG_ETHERTYPE  = 3'd2;
    localparam logic [2:0]  REG_GAP_LOW    = 3'd3;
    localparam logic [2:0]  REG_GAP_HIGH   = 3'd4;

    localparam logic [15:0] ETHERTYPE_RESET = 16'hd00d;
    localparam logic [19:0] GAP_LOW_RESET   = 20'd800;
    localparam logic [19:0] GAP_HIGH_RESET  = 20'd1200;
    localparam logic [19:0] US_PER_SECOND   = 20'd1000000;

    // Last source seen on a span: none, first or second.
    localparam logic [1:0]  SRC_NONE   = 2'd0;
    localparam logic [1:0]  SRC_FIRST  = 2'd1;
    localparam logic [1:0]  SRC_SECOND = 2'd2;

    localparam int FIFO_DEPTH = tfgm_pkg::OUT_FIFO_DEPTH;
    localparam int CNT_W      = $clog2(FIFO_DEPTH) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] first_mac_reg;
    logic [47:0] second_mac_reg;
    logic [15:0] ethertype_reg;
    logic [19:0] gap_low_reg;
    logic [19:0] gap_high_reg;
    logic        cfg_write;
    logic [2:0]  cfg_sel;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_mac_reg  <= '0;
            second_mac_reg <= '0;
            ethertype_reg  <= ETHERTYPE_RESET;
            gap_low_reg    <= GAP_LOW_RESET;
            gap_high_reg   <= GAP_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_FIRST_MAC:  first_mac_reg  <= pwdata[47:0];
                REG_SECOND_MAC: second_mac_reg <= pwdata[47:0];
                REG_ETHERTYPE:  ethertype_reg  <= pwdata[15:0];
                REG_GAP_LOW:    gap_low_reg    <= pwdata[19:0];
                REG_GAP_HIGH:   gap_high_reg   <= pwdata[19:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_FIRST_MAC:  prdata = {16'd0, first_mac_reg};
            REG_SECOND_MAC: prdata = {16'd0, second_mac_reg};
            REG_ETHERTYPE:  prdata = {48'd0, ethertype_reg};
            REG_GAP_LOW:    prdata = {44'd0, gap_low_reg};
            REG_GAP_HIGH:   prdata = {44'd0, gap_high_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0: classify the frame, track ordering per span, and start the
    // timestamp conversion.
    // ------------------------------------------------------------------
    logic [47:0]                in_mac;
    logic [15:0]                in_etype;
    logic [15:0]                in_span;
    logic [31:0]                in_secs;
    logic [19:0]                in_micros;
    logic [SPAN_W-1:0]          in_span_idx;
    tfgm_pkg::frame_class_t     in_cls;
    logic                       in_stream;
    logic [1:0]                 in_src_code;
    logic                       in_oerr;
    logic [STREAM_W-1:0]        in_idx;
    logic                       accept;

    logic [1:0]                 last_src_reg [NUM_SPANS];

    assign in_mac      = s_tdata[47:0];
    assign in_etype    = s_tdata[63:48];
    assign in_span     = s_tdata[79:64];
    assign in_secs     = s_tdata[111:80];
    assign in_micros   = s_tdata[131:112];
    assign in_span_idx = in_span[SPAN_W-1:0];
    assign accept      = s_tvalid && s_tready;

    always_comb
    begin
        // Ethertype first, then span range, then the MACs; equal MAC
        // registers resolve to the first source.
        if (in_etype != ethertype_reg)
        begin
            in_cls = tfgm_pkg::CLS_NOT_TDM;
        end
        else if (in_span >= 16'(NUM_SPANS))
        begin
            in_cls = tfgm_pkg::CLS_SPAN_RANGE;
        end
        else if (in_mac == first_mac_reg)
        begin
            in_cls = tfgm_pkg::CLS_FIRST;
        end
        else if (in_mac == second_mac_reg)
        begin
            in_cls = tfgm_pkg::CLS_SECOND;
        end
        else
        begin
            in_cls = tfgm_pkg::CLS_OTHER;
        end

        in_stream   = tfgm_pkg::is_stream(in_cls);
        in_src_code = (in_cls == tfgm_pkg::CLS_SECOND) ? SRC_SECOND : SRC_FIRST;
        in_oerr     = in_stream && (last_src_reg[in_span_idx] == in_src_code);
        in_idx      = in_stream ? {in_span_idx, in_cls == tfgm_pkg::CLS_SECOND} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SPANS; i++)
            begin
                last_src_reg[i] <= SRC_NONE;
            end
        end
        else if (accept && in_stream)
        begin
            last_src_reg[in_span_idx] <= in_src_code;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                         p1_valid_reg;
    tfgm_pkg::frame_class_t       p1_cls_reg;
    logic [STREAM_W-1:0]          p1_idx_reg;
    logic                         p1_oerr_reg;
    logic [tfgm_pkg::TIME_W-1:0]  p1_prod_reg;
    logic [19:0]                  p1_micros_reg;

    logic                         p2_valid_reg;
    logic [STREAM_W-1:0]          p2_idx_reg;
    tfgm_pkg::tim_req_t           p2_req_reg;
    tfgm_pkg::tim_req_t           p2_req_next;

    logic                         p3_valid_reg;
    logic [STREAM_W-1:0]          p3_idx_reg;
    tfgm_pkg::tim_res_t           p3_res_reg;

    tfgm_pkg::tim_res_t           tim_res;
    tfgm_pkg::result_t            stat_res;

    // Stage 1 finishes the timestamp in microseconds.
    always_comb
    begin
        p2_req_next.cls  = p1_cls_reg;
        p2_req_next.oerr = p1_oerr_reg;
        p2_req_next.now  = p1_prod_reg + {32'd0, p1_micros_reg};
    end

    always_ff @(posedge clk)
    begin
        p1_cls_reg    <= in_cls;
        p1_idx_reg    <= in_idx;
        p1_oerr_reg   <= in_oerr;
        p1_prod_reg   <= {20'd0, in_secs} * {32'd0, US_PER_SECOND};
        p1_micros_reg <= in_micros;
        p2_idx_reg    <= p1_idx_reg;
        p2_req_reg    <= p2_req_next;
        p3_idx_reg    <= p2_idx_reg;
        p3_res_reg    <= tim_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // Stage 2: timing memory (read issued from stage 1).
    tfgm_timing #(
        .NUM_SPANS (NUM_SPANS)
    ) u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .gap_low   (gap_low_reg),
        .gap_high  (gap_high_reg),
        .rd_idx    (p1_idx_reg),
        .cur_valid (p2_valid_reg),
        .cur_idx   (p2_idx_reg),
        .cur       (p2_req_reg),
        .res       (tim_res)
    );

    // Stage 3: statistics memory (read issued from stage 2).
    tfgm_stats #(
        .NUM_SPANS (NUM_SPANS)
    ) u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (p2_idx_reg),
        .cur_valid (p3_valid_reg),
        .cur_idx   (p3_idx_reg),
        .cur       (p3_res_reg),
        .res       (stat_res)
    );

    // ------------------------------------------------------------------
    // Output queue and flow control
    // ------------------------------------------------------------------
    tfgm_pkg::result_t  m_res;
    logic [CNT_W-1:0]   fifo_count;
    logic [CNT_W:0]     credit_used;

    tfgm_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p3_valid_reg),
        .push_data (stat_res),
        .pop       (m_tready),
        .head      (m_res),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    // Every item in the pipeline has a slot reserved in the queue.
    assign credit_used = {1'b0, fifo_count}
                       + (CNT_W + 1)'(p1_valid_reg)
                       + (CNT_W + 1)'(p2_valid_reg)
                       + (CNT_W + 1)'(p3_valid_reg);
    assign s_tready    = credit_used < (CNT_W + 1)'(FIFO_DEPTH);

    assign m_tdata = {2'b00,
                      m_res.gap_square_sum,
                      m_res.gap_sum,
                      m_res.accepted_count,
                      m_res.order_error_count,
                      m_res.max_gap_us,
                      m_res.min_gap_us,
                      m_res.frame_count,
                      m_res.order_error,
                      m_res.gap_us,
                      m_res.gap_status,
                      m_res.frame_class};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> (fifo_count < CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_non_stream_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_res.frame_class != tfgm_pkg::CLS_FIRST)
                 && (m_res.frame_class != tfgm_pkg::CLS_SECOND)
        |-> (m_res.frame_count == '0) && (m_res.gap_us == '0)
            && (m_res.gap_status == tfgm_pkg::GAP_NONE) && (m_res.gap_sum == '0))
        else $error("non-stream frame carries statistics");

    a_in_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_res.gap_status == tfgm_pkg::GAP_IN)
        |-> ({12'd0, m_res.min_gap_us} <= m_res.gap_us)
            && (m_res.gap_us <= {12'd0, m_res.max_gap_us}))
        else $error("in-window gap outside recorded min and max");

    a_accepted_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_res.frame_class == tfgm_pkg::CLS_FIRST)
                  || (m_res.frame_class == tfgm_pkg::CLS_SECOND))
        |-> m_res.accepted_count <= m_res.frame_count)
        else $error("accepted gaps exceed frames on stream");

endmodule
